FILE: src/snwp_pkg.sv
// Shared types, constants and helper functions of the sensor node wake policy.
`default_nettype none

package snwp_pkg;

  // Field widths
  localparam int RawW     = 12;
  localparam int MvW      = 13;
  localparam int PctW     = 7;
  localparam int BandW    = 3;
  localparam int CntW     = 16;
  localparam int LowW     = 14;
  localparam int PhaseW   = 6;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 13;

  // Policy constants
  localparam int HEARTBEAT_WAKES = 48;
  localparam int REDRAW_STEP     = 3;

  localparam logic [PctW-1:0] BandEdgeGood  = 7'd40;
  localparam logic [PctW-1:0] BandEdgeMoist = 7'd70;
  localparam logic [PctW-1:0] PctFull       = 7'd100;
  localparam logic [LowW-1:0] LowWaterReset = 14'd9999;
  localparam logic [CntW-1:0] TallyMax      = 16'hFFFF;

  // Serial divider sizing: |raw - dry| * 100 fits in 19 bits
  localparam int NumW     = 19;
  localparam int DivSteps = NumW;
  localparam int StepCntW = 5;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DRY      = 3'd0,
    CFG_WET      = 3'd1,
    CFG_VALID    = 3'd2,
    CFG_SUSPECT  = 3'd3,
    CFG_CONSERVE = 3'd4,
    CFG_RESUME   = 3'd5,
    CFG_ALERT_LO = 3'd6,
    CFG_ALERT_HI = 3'd7
  } cfg_idx_e;

  // Status band codes
  typedef enum logic [BandW-1:0] {
    BAND_VERY_DRY = 3'd0,
    BAND_NEEDS    = 3'd1,
    BAND_GOOD     = 3'd2,
    BAND_MOIST    = 3'd3,
    BAND_VERY_WET = 3'd4
  } band_e;

  // Sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DIV  = 1'b1
  } state_e;

  typedef struct packed {
    logic [RawW-1:0] dry;
    logic [RawW-1:0] wet;
    logic [MvW-1:0]  valid_mv;
    logic [MvW-1:0]  suspect_mv;
    logic [MvW-1:0]  conserve_mv;
    logic [MvW-1:0]  resume_mv;
    logic [PctW-1:0] alert_lo;
    logic [PctW-1:0] alert_hi;
  } cfg_t;

  typedef struct packed {
    logic [PctW-1:0]  moisture_pct;
    logic [BandW-1:0] status_band;
    logic             battery_valid;
    logic             battery_suspect;
    logic             conserving_now;
    logic             radio_alert;
    logic             heartbeat_due;
    logic             send_radio;
    logic             redraw;
    logic             long_sleep;
    logic [CntW-1:0]  brownout_count;
    logic [LowW-1:0]  min_battery_mv;
  } result_t;

  // Five-band classification of a percentage.
  function automatic band_e band_of(input logic [PctW-1:0] p,
                                    input logic [PctW-1:0] lo,
                                    input logic [PctW-1:0] hi);
    band_e b;
    if (p < lo) begin
      b = BAND_VERY_DRY;
    end else if (p < BandEdgeGood) begin
      b = BAND_NEEDS;
    end else if (p < BandEdgeMoist) begin
      b = BAND_GOOD;
    end else if (p < hi) begin
      b = BAND_MOIST;
    end else begin
      b = BAND_VERY_WET;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: src/snwp_if.sv
// Handshake channel interfaces: input items, result items and configuration writes.
`default_nettype none

interface snwp_in_if;
  import snwp_pkg::*;
  logic             valid;
  logic             ready;
  logic [RawW-1:0]  moisture_raw;
  logic [MvW-1:0]   battery_mv;
  logic             brownout_reset;

  modport source (output valid, output moisture_raw, output battery_mv,
                  output brownout_reset, input ready);
  modport sink   (input valid, input moisture_raw, input battery_mv,
                  input brownout_reset, output ready);
endinterface

interface snwp_out_if;
  import snwp_pkg::*;
  logic             valid;
  logic             ready;
  logic [PctW-1:0]  moisture_pct;
  logic [BandW-1:0] status_band;
  logic             battery_valid;
  logic             battery_suspect;
  logic             conserving_now;
  logic             radio_alert;
  logic             heartbeat_due;
  logic             send_radio;
  logic             redraw;
  logic             long_sleep;
  logic [CntW-1:0]  brownout_count;
  logic [LowW-1:0]  min_battery_mv;

  modport source (output valid, output moisture_pct, output status_band,
                  output battery_valid, output battery_suspect, output conserving_now,
                  output radio_alert, output heartbeat_due, output send_radio,
                  output redraw, output long_sleep, output brownout_count,
                  output min_battery_mv, input ready);
  modport sink   (input valid, input moisture_pct, input status_band,
                  input battery_valid, input battery_suspect, input conserving_now,
                  input radio_alert, input heartbeat_due, input send_radio,
                  input redraw, input long_sleep, input brownout_count,
                  input min_battery_mv, output ready);
endinterface

interface snwp_cfg_if;
  import snwp_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/snwp_cfg_regs.sv
// Configuration register file with reset calibration and thresholds.
`default_nettype none

module snwp_cfg_regs (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  snwp_cfg_if.sink            cfg_i,
  output snwp_pkg::cfg_t      cfg_o
);
  import snwp_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Writes are always taken.
  assign cfg_i.ready = 1'b1;

  // Register selection by index.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_DRY:      cfg_d.dry         = cfg_i.data[RawW-1:0];
        CFG_WET:      cfg_d.wet         = cfg_i.data[RawW-1:0];
        CFG_VALID:    cfg_d.valid_mv    = cfg_i.data[MvW-1:0];
        CFG_SUSPECT:  cfg_d.suspect_mv  = cfg_i.data[MvW-1:0];
        CFG_CONSERVE: cfg_d.conserve_mv = cfg_i.data[MvW-1:0];
        CFG_RESUME:   cfg_d.resume_mv   = cfg_i.data[MvW-1:0];
        CFG_ALERT_LO: cfg_d.alert_lo    = cfg_i.data[PctW-1:0];
        CFG_ALERT_HI: cfg_d.alert_hi    = cfg_i.data[PctW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dry         <= 12'd3160;
      cfg_q.wet         <= 12'd1300;
      cfg_q.valid_mv    <= 13'd2500;
      cfg_q.suspect_mv  <= 13'd3600;
      cfg_q.conserve_mv <= 13'd3500;
      cfg_q.resume_mv   <= 13'd3650;
      cfg_q.alert_lo    <= 7'd20;
      cfg_q.alert_hi    <= 7'd90;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: src/snwp_serial_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
`default_nettype none

module snwp_serial_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [snwp_pkg::NumW-1:0]  dividend_i,
  input  wire logic [snwp_pkg::RawW-1:0]  divisor_i,
  output      logic                       busy_o,
  output      logic [snwp_pkg::NumW-1:0]  quotient_o
);
  import snwp_pkg::*;

  logic                busy_q, busy_d;
  logic [StepCntW-1:0] step_q, step_d;
  logic [RawW-1:0]     rem_q, rem_d;
  logic [NumW-1:0]     quo_q, quo_d;
  logic [RawW-1:0]     den_q, den_d;
  logic [RawW:0]       shifted;
  logic [RawW:0]       trial;

  // One subtract-and-compare step: bring down the next dividend bit.
  always_comb begin
    shifted = {rem_q, quo_q[NumW-1]};
    trial   = shifted - {1'b0, den_q};
    busy_d  = busy_q;
    step_d  = step_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      den_d  = divisor_i;
    end else if (busy_q) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_d = trial[RawW-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = shifted[RawW-1:0];
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == StepCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

FILE: src/snwp_policy.sv
// Battery classification, conservation latch, redraw decision and wake counters.
`default_nettype none

module snwp_policy (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire snwp_pkg::cfg_t             cfg_i,
  input  wire logic [snwp_pkg::PctW-1:0]  pct_i,
  input  wire logic [snwp_pkg::MvW-1:0]   mv_i,
  input  wire logic                       brown_i,
  input  wire logic                       commit_i,
  output      snwp_pkg::result_t          result_o
);
  import snwp_pkg::*;

  logic              latch_q, latch_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic              drawn_valid_q, drawn_valid_d;
  logic [PctW-1:0]   drawn_pct_q, drawn_pct_d;
  logic              drawn_alert_q, drawn_alert_d;
  logic              drawn_suspect_q, drawn_suspect_d;
  logic              drawn_cons_q, drawn_cons_d;
  logic [CntW-1:0]   tally_q, tally_d;
  logic [LowW-1:0]   lowest_q, lowest_d;

  logic              latch_brown;
  logic              valid, suspect, disp_alert, radio_alert, heartbeat, redraw;
  logic [PctW-1:0]   pct_diff;
  logic [PhaseW:0]   phase_inc;
  band_e             band_now;

  always_comb begin
    // Brownout first: count it and set the latch.
    tally_d     = (brown_i && tally_q != TallyMax) ? tally_q + 1'b1 : tally_q;
    latch_brown = latch_q | brown_i;

    valid   = mv_i >= cfg_i.valid_mv;
    suspect = valid && (mv_i <= cfg_i.suspect_mv);

    // Low-water mark and voltage hysteresis, only on a valid reading.
    lowest_d = lowest_q;
    latch_d  = latch_brown;
    if (valid) begin
      if ({1'b0, mv_i} < lowest_q) begin
        lowest_d = {1'b0, mv_i};
      end
      if (latch_brown) begin
        latch_d = !(mv_i >= cfg_i.resume_mv);
      end else begin
        latch_d = mv_i <= cfg_i.conserve_mv;
      end
    end

    band_now    = band_of(pct_i, cfg_i.alert_lo, cfg_i.alert_hi);
    disp_alert  = (pct_i < cfg_i.alert_lo) || (pct_i > cfg_i.alert_hi);
    radio_alert = valid && !suspect && disp_alert;
    heartbeat   = phase_q == '0;
    pct_diff    = (pct_i >= drawn_pct_q) ? pct_i - drawn_pct_q : drawn_pct_q - pct_i;

    // Display refresh decision.
    if (!drawn_valid_q || heartbeat) begin
      redraw = 1'b1;
    end else if (latch_d != drawn_cons_q) begin
      redraw = 1'b1;
    end else if (disp_alert != drawn_alert_q) begin
      redraw = 1'b1;
    end else if (suspect != drawn_suspect_q) begin
      redraw = 1'b1;
    end else if (latch_d) begin
      redraw = 1'b0;
    end else begin
      redraw = (pct_diff >= PctW'(REDRAW_STEP)) ||
               (band_now != band_of(drawn_pct_q, cfg_i.alert_lo, cfg_i.alert_hi));
    end

    drawn_valid_d   = drawn_valid_q | redraw;
    drawn_pct_d     = redraw ? pct_i : drawn_pct_q;
    drawn_alert_d   = redraw ? disp_alert : drawn_alert_q;
    drawn_suspect_d = redraw ? suspect : drawn_suspect_q;
    drawn_cons_d    = redraw ? latch_d : drawn_cons_q;

    // Wake phase wraps at the heartbeat period.
    phase_inc = {1'b0, phase_q} + 1'b1;
    phase_d   = (phase_inc >= (PhaseW+1)'(HEARTBEAT_WAKES)) ? '0 : phase_inc[PhaseW-1:0];

    result_o.moisture_pct    = pct_i;
    result_o.status_band     = band_now;
    result_o.battery_valid   = valid;
    result_o.battery_suspect = suspect;
    result_o.conserving_now  = latch_d;
    result_o.radio_alert     = radio_alert;
    result_o.heartbeat_due   = heartbeat;
    result_o.send_radio      = !latch_d && (radio_alert || heartbeat);
    result_o.redraw          = redraw;
    result_o.long_sleep      = latch_d;
    result_o.brownout_count  = tally_d;
    result_o.min_battery_mv  = lowest_d;
  end

  // Policy state advances once per item, when its result is registered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q         <= 1'b0;
      phase_q         <= '0;
      drawn_valid_q   <= 1'b0;
      drawn_pct_q     <= '0;
      drawn_alert_q   <= 1'b0;
      drawn_suspect_q <= 1'b0;
      drawn_cons_q    <= 1'b0;
      tally_q         <= '0;
      lowest_q        <= LowWaterReset;
    end else if (commit_i) begin
      latch_q         <= latch_d;
      phase_q         <= phase_d;
      drawn_valid_q   <= drawn_valid_d;
      drawn_pct_q     <= drawn_pct_d;
      drawn_alert_q   <= drawn_alert_d;
      drawn_suspect_q <= drawn_suspect_d;
      drawn_cons_q    <= drawn_cons_d;
      tally_q         <= tally_d;
      lowest_q        <= lowest_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/sensor_node_wake_policy.sv
// An accepted item starts the 19-step serial divider of the percentage map; the
// result is registered once the divider is done and any earlier result has been
// taken. No new item is accepted until then.
// The output register holds a result while the next item is already computing.
// Reset (asynchronous, active low) restores the calibration and threshold
// registers, clears the latch, counters and display record, and sets the low-water mark to 9999.
`default_nettype none

module sensor_node_wake_policy (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  snwp_in_if.sink     in_i,
  snwp_out_if.source  out_o,
  snwp_cfg_if.sink    cfg_i
);
  import snwp_pkg::*;

  state_e           state_q, state_d;
  cfg_t             cfg;
  logic             in_accept;
  logic             load_out;
  logic             div_busy;
  logic [NumW-1:0]  quotient;
  logic [RawW-1:0]  num_mag, span_mag;
  logic             num_neg, span_neg;
  logic [NumW-1:0]  dividend;
  logic [PctW-1:0]  pct;

  logic [MvW-1:0]   mv_q;
  logic             brown_q;
  logic             neg_q;
  logic             span_zero_q;
  logic             out_valid_q, out_valid_d;
  result_t          res_q;
  result_t          policy_res;

  snwp_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Sign and magnitude of the numerator and span, numerator scaled by 100.
  always_comb begin
    num_neg  = in_i.moisture_raw < cfg.dry;
    num_mag  = num_neg ? cfg.dry - in_i.moisture_raw : in_i.moisture_raw - cfg.dry;
    span_neg = cfg.wet < cfg.dry;
    span_mag = span_neg ? cfg.dry - cfg.wet : cfg.wet - cfg.dry;
    dividend = {1'b0, num_mag, 6'b0} + {2'b0, num_mag, 5'b0} + {5'b0, num_mag, 2'b0};
  end

  assign in_accept  = in_i.valid && in_i.ready;
  assign in_i.ready = state_q == ST_IDLE;

  snwp_serial_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_accept),
    .dividend_i (dividend),
    .divisor_i  (span_mag),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // Truncated quotient clamped to 0..100; a negative map or equal points give 0.
  always_comb begin
    if (span_zero_q || neg_q) begin
      pct = '0;
    end else if (quotient > NumW'(PctFull)) begin
      pct = PctFull;
    end else begin
      pct = quotient[PctW-1:0];
    end
  end

  snwp_policy u_policy (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .pct_i    (pct),
    .mv_i     (mv_q),
    .brown_i  (brown_q),
    .commit_i (load_out),
    .result_o (policy_res)
  );

  // Sequencer: wait for the divider and a free output register, then hand the result to it.
  always_comb begin
    state_d     = state_q;
    load_out    = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!div_busy && (!out_valid_q || out_o.ready)) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Item capture and result register.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mv_q        <= in_i.battery_mv;
      brown_q     <= in_i.brownout_reset;
      neg_q       <= num_neg ^ span_neg;
      span_zero_q <= span_mag == '0;
    end
    if (load_out) begin
      res_q <= policy_res;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.moisture_pct    = res_q.moisture_pct;
  assign out_o.status_band     = res_q.status_band;
  assign out_o.battery_valid   = res_q.battery_valid;
  assign out_o.battery_suspect = res_q.battery_suspect;
  assign out_o.conserving_now  = res_q.conserving_now;
  assign out_o.radio_alert     = res_q.radio_alert;
  assign out_o.heartbeat_due   = res_q.heartbeat_due;
  assign out_o.send_radio      = res_q.send_radio;
  assign out_o.redraw          = res_q.redraw;
  assign out_o.long_sleep      = res_q.long_sleep;
  assign out_o.brownout_count  = res_q.brownout_count;
  assign out_o.min_battery_mv  = res_q.min_battery_mv;

endmodule

`default_nettype wire

FILE: src/snwp_checker.sv
// Port-level assertions for the wake policy block and their binding to it.
`default_nettype none

module snwp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [6:0] out_pct_i,
  input wire logic [2:0] out_band_i,
  input wire logic       out_conserving_i,
  input wire logic       out_long_sleep_i,
  input wire logic       out_send_i
);

  // An accepted item keeps the input closed for the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready straight after an accepted item");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_pct_i) && $stable(out_band_i))
    else $error("stalled result changed");

  // The percentage stays clamped and the band stays one of five.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_pct_i <= 7'd100 && out_band_i <= 3'd4)
    else $error("percentage or band out of range");

  // Long sleep follows the latch and a conserving node sends nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_long_sleep_i == out_conserving_i) &&
                    !(out_send_i && out_conserving_i))
    else $error("sleep or radio decision disagrees with conservation");

endmodule

bind sensor_node_wake_policy snwp_checker u_snwp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_pct_i        (out_o.moisture_pct),
  .out_band_i       (out_o.status_band),
  .out_conserving_i (out_o.conserving_now),
  .out_long_sleep_i (out_o.long_sleep),
  .out_send_i       (out_o.send_radio)
);

`default_nettype wire

FILE: test/sensor_node_wake_policy_tb.sv
// Self-checking testbench of the sensor node wake policy: directed and random wakes.
module sensor_node_wake_policy_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import snwp_pkg::*;

  // Mirror of the wake policy: calibration, latch, display record and counters,
  // plus the queue of decisions still awaited from the block.
  class wake_policy_shadow;
    cfg_t            cal;
    bit              conserving;
    int unsigned     phase;
    bit              drawn_ok;
    int              drawn_pct;
    bit              drawn_alert;
    bit              drawn_suspect;
    bit              drawn_cons;
    int unsigned     tally;
    logic [LowW-1:0] lowest;
    result_t         awaited[$];
    int unsigned     faults;

    function new();
      cal.dry         = 12'd3160;
      cal.wet         = 12'd1300;
      cal.valid_mv    = 13'd2500;
      cal.suspect_mv  = 13'd3600;
      cal.conserve_mv = 13'd3500;
      cal.resume_mv   = 13'd3650;
      cal.alert_lo    = 7'd20;
      cal.alert_hi    = 7'd90;
      conserving      = 1'b0;
      phase           = 0;
      drawn_ok        = 1'b0;
      drawn_pct       = 0;
      drawn_alert     = 1'b0;
      drawn_suspect   = 1'b0;
      drawn_cons      = 1'b0;
      tally           = 0;
      lowest          = LowWaterReset;
      faults          = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] d);
      case (idx)
        CFG_DRY:      cal.dry         = d[RawW-1:0];
        CFG_WET:      cal.wet         = d[RawW-1:0];
        CFG_VALID:    cal.valid_mv    = d[MvW-1:0];
        CFG_SUSPECT:  cal.suspect_mv  = d[MvW-1:0];
        CFG_CONSERVE: cal.conserve_mv = d[MvW-1:0];
        CFG_RESUME:   cal.resume_mv   = d[MvW-1:0];
        CFG_ALERT_LO: cal.alert_lo    = d[PctW-1:0];
        CFG_ALERT_HI: cal.alert_hi    = d[PctW-1:0];
        default: ;
      endcase
    endfunction

    // Signed two-point map, truncating toward zero, then clamped to 0..100.
    function int percent_of(logic [RawW-1:0] raw);
      int span;
      int v;
      span = int'(cal.wet) - int'(cal.dry);
      if (span == 0) begin
        return 0;
      end
      v = (int'(raw) - int'(cal.dry)) * 100 / span;
      if (v < 0) begin
        v = 0;
      end
      if (v > 100) begin
        v = 100;
      end
      return v;
    endfunction

    function band_e band_for(int p);
      if (p < int'(cal.alert_lo)) begin
        return BAND_VERY_DRY;
      end else if (p < 40) begin
        return BAND_NEEDS;
      end else if (p < 70) begin
        return BAND_GOOD;
      end else if (p < int'(cal.alert_hi)) begin
        return BAND_MOIST;
      end
      return BAND_VERY_WET;
    endfunction

    // Works out the decision of one accepted wake and queues it.
    function void note_wake(logic [RawW-1:0] raw, logic [MvW-1:0] mv, logic brown);
      int      p;
      int      diff;
      bit      valid;
      bit      suspect;
      bit      disp_alert;
      bit      radio;
      bit      beat;
      bit      redraw;
      result_t r;
      if (brown) begin
        if (tally < TallyMax) begin
          tally++;
        end
        conserving = 1'b1;
      end
      valid   = mv >= cal.valid_mv;
      suspect = valid && (mv <= cal.suspect_mv);
      // Hysteresis only acts on a trustworthy reading, so a brownout wake can release.
      if (valid) begin
        if (mv < lowest) begin
          lowest = {1'b0, mv};
        end
        if (conserving) begin
          if (mv >= cal.resume_mv) begin
            conserving = 1'b0;
          end
        end else if (mv <= cal.conserve_mv) begin
          conserving = 1'b1;
        end
      end
      p          = percent_of(raw);
      disp_alert = (p < int'(cal.alert_lo)) || (p > int'(cal.alert_hi));
      radio      = valid && !suspect && disp_alert;
      beat       = phase == 0;
      // Display refresh decision, most urgent reasons first.
      if (!drawn_ok || beat) begin
        redraw = 1'b1;
      end else if (conserving != drawn_cons) begin
        redraw = 1'b1;
      end else if (disp_alert != drawn_alert) begin
        redraw = 1'b1;
      end else if (suspect != drawn_suspect) begin
        redraw = 1'b1;
      end else if (conserving) begin
        redraw = 1'b0;
      end else begin
        diff   = (p > drawn_pct) ? p - drawn_pct : drawn_pct - p;
        redraw = (diff >= REDRAW_STEP) || (band_for(p) != band_for(drawn_pct));
      end
      if (redraw) begin
        drawn_ok      = 1'b1;
        drawn_pct     = p;
        drawn_alert   = disp_alert;
        drawn_suspect = suspect;
        drawn_cons    = conserving;
      end
      phase = (phase + 1 >= HEARTBEAT_WAKES) ? 0 : phase + 1;

      r.moisture_pct    = p[PctW-1:0];
      r.status_band     = band_for(p);
      r.battery_valid   = valid;
      r.battery_suspect = suspect;
      r.conserving_now  = conserving;
      r.radio_alert     = radio;
      r.heartbeat_due   = beat;
      r.send_radio      = !conserving && (radio || beat);
      r.redraw          = redraw;
      r.long_sleep      = conserving;
      r.brownout_count  = tally[CntW-1:0];
      r.min_battery_mv  = lowest;
      awaited.push_back(r);
    endfunction

    function void compare(string name, logic [CntW-1:0] want, logic [CntW-1:0] got);
      if (want !== got) begin
        faults++;
        $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    // Checks one delivered decision against the oldest one awaited.
    function void check_outcome(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        faults++;
        $display("%0t ns: result with none awaited, expected none, got pct %0d count %0d",
                 $time, got.moisture_pct, got.brownout_count);
        return;
      end
      want = awaited.pop_front();
      compare("moisture_pct", CntW'(want.moisture_pct), CntW'(got.moisture_pct));
      compare("status_band", CntW'(want.status_band), CntW'(got.status_band));
      compare("battery_valid", CntW'(want.battery_valid), CntW'(got.battery_valid));
      compare("battery_suspect", CntW'(want.battery_suspect), CntW'(got.battery_suspect));
      compare("conserving_now", CntW'(want.conserving_now), CntW'(got.conserving_now));
      compare("radio_alert", CntW'(want.radio_alert), CntW'(got.radio_alert));
      compare("heartbeat_due", CntW'(want.heartbeat_due), CntW'(got.heartbeat_due));
      compare("send_radio", CntW'(want.send_radio), CntW'(got.send_radio));
      compare("redraw", CntW'(want.redraw), CntW'(got.redraw));
      compare("long_sleep", CntW'(want.long_sleep), CntW'(got.long_sleep));
      compare("brownout_count", want.brownout_count, got.brownout_count);
      compare("min_battery_mv", CntW'(want.min_battery_mv), CntW'(got.min_battery_mv));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  snwp_in_if  in_if ();
  snwp_out_if out_if ();
  snwp_cfg_if cfg_if ();

  sensor_node_wake_policy uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  wake_policy_shadow shadow;
  int raw_walk;
  int mv_walk;
  int burst_left;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit.
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int clamp_to(int v, int hi);
    if (v < 0) begin
      return 0;
    end
    return (v > hi) ? hi : v;
  endfunction

  // Offers one wake item and notes it once the block has taken it.
  task automatic offer_wake(logic [RawW-1:0] raw, logic [MvW-1:0] mv, logic brown);
    @(negedge clk);
    in_if.valid          <= 1'b1;
    in_if.moisture_raw   <= raw;
    in_if.battery_mv     <= mv;
    in_if.brownout_reset <= brown;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    shadow.note_wake(raw, mv, brown);
  endtask

  task automatic idle_input(int n);
    @(negedge clk);
    in_if.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] d);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    shadow.set_reg(idx, d);
  endtask

  // Waits until every decision is in, then rewrites the whole calibration.
  task automatic apply_cal(logic [RawW-1:0] dry, wet, logic [MvW-1:0] vld, sus, con, res,
                           logic [PctW-1:0] lo, hi);
    idle_input(1);
    while (shadow.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(CFG_DRY, CfgDataW'(dry));
    write_reg(CFG_WET, CfgDataW'(wet));
    write_reg(CFG_VALID, vld);
    write_reg(CFG_SUSPECT, sus);
    write_reg(CFG_CONSERVE, con);
    write_reg(CFG_RESUME, res);
    write_reg(CFG_ALERT_LO, CfgDataW'(lo));
    write_reg(CFG_ALERT_HI, CfgDataW'(hi));
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Result receiver: stalls on a periodic pattern that changes now and then.
  initial begin
    int tick;
    int stall_period;
    int stall_len;
    out_if.ready = 1'b0;
    tick         = 0;
    stall_period = 1;
    stall_len    = 0;
    forever begin
      @(negedge clk);
      if (tick % 300 == 0) begin
        stall_period = $urandom_range(2, 9);
        stall_len    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, stall_period - 1);
      end
      out_if.ready <= ((tick % stall_period) >= stall_len);
      tick++;
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      shadow.check_outcome('{moisture_pct:    out_if.moisture_pct,
                             status_band:     out_if.status_band,
                             battery_valid:   out_if.battery_valid,
                             battery_suspect: out_if.battery_suspect,
                             conserving_now:  out_if.conserving_now,
                             radio_alert:     out_if.radio_alert,
                             heartbeat_due:   out_if.heartbeat_due,
                             send_radio:      out_if.send_radio,
                             redraw:          out_if.redraw,
                             long_sleep:      out_if.long_sleep,
                             brownout_count:  out_if.brownout_count,
                             min_battery_mv:  out_if.min_battery_mv});
    end
  end

  // Stimulus.
  initial begin
    logic [RawW-1:0] c_dry, c_wet;
    logic [MvW-1:0]  c_vld, c_sus, c_con, c_res;
    logic [PctW-1:0] c_lo, c_hi;
    int              pick;
    int              cal_lo, cal_hi;
    logic            brown;
    shadow                = new();
    rst_n                 = 1'b0;
    in_if.valid           = 1'b0;
    in_if.moisture_raw    = '0;
    in_if.battery_mv      = '0;
    in_if.brownout_reset  = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = CFG_DRY;
    cfg_if.data           = '0;
    raw_walk              = 2200;
    mv_walk               = 3600;
    burst_left            = 1;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed wakes on the reset calibration: clamps, battery edges, hysteresis.
    offer_wake(12'd0, 13'd8191, 1'b0);
    offer_wake(12'd4095, 13'd0, 1'b0);
    offer_wake(12'd3160, 13'd2499, 1'b0);
    offer_wake(12'd1300, 13'd2500, 1'b0);
    offer_wake(12'd2230, 13'd3650, 1'b0);
    offer_wake(12'd2230, 13'd3600, 1'b0);
    offer_wake(12'd2231, 13'd3500, 1'b0);
    offer_wake(12'd2200, 13'd3649, 1'b0);
    offer_wake(12'd2200, 13'd8191, 1'b1);
    offer_wake(12'd2200, 13'd0, 1'b1);
    offer_wake(12'd2200, 13'd5000, 1'b0);
    offer_wake(12'd2190, 13'd5000, 1'b0);
    offer_wake(12'd2170, 13'd5000, 1'b0);
    offer_wake(12'd2100, 13'd5000, 1'b0);
    // Equal dry and wet points.
    apply_cal(12'd2000, 12'd2000, 13'd2500, 13'd3600, 13'd3500, 13'd3650, 7'd20, 7'd90);
    offer_wake(12'd2000, 13'd4000, 1'b0);
    offer_wake(12'd4095, 13'd4000, 1'b0);
    // Inverted, then normal, calibration at both extremes.
    apply_cal(12'd0, 12'd4095, 13'd2500, 13'd3600, 13'd3500, 13'd3650, 7'd20, 7'd90);
    offer_wake(12'd4095, 13'd3000, 1'b0);
    offer_wake(12'd2048, 13'd3000, 1'b0);
    apply_cal(12'd4095, 12'd0, 13'd2500, 13'd3600, 13'd3500, 13'd3650, 7'd20, 7'd90);
    offer_wake(12'd0, 13'd3000, 1'b0);
    offer_wake(12'd4095, 13'd3000, 1'b0);
    // Thresholds out of order.
    apply_cal(12'd3160, 12'd1300, 13'd0, 13'd8191, 13'd0, 13'd8191, 7'd100, 7'd0);
    offer_wake(12'd1000, 13'd0, 1'b0);
    offer_wake(12'd4095, 13'd8191, 1'b1);
    apply_cal(12'd3160, 12'd1300, 13'd8191, 13'd0, 13'd8191, 13'd0, 7'd0, 7'd100);
    offer_wake(12'd2000, 13'd8191, 1'b0);
    offer_wake(12'd3000, 13'd100, 1'b0);

    // Random phases, each under a fresh calibration.
    for (int ph = 0; ph < 12; ph++) begin
      c_dry = RawW'($urandom_range(2400, 4095));
      c_wet = RawW'($urandom_range(0, 1800));
      c_vld = MvW'($urandom_range(2000, 3000));
      c_con = c_vld + MvW'($urandom_range(0, 1000));
      c_sus = c_con + MvW'($urandom_range(0, 300));
      c_res = c_sus + MvW'($urandom_range(0, 300));
      c_lo  = PctW'($urandom_range(0, 45));
      c_hi  = PctW'($urandom_range(60, 100));
      case (ph % 4)
        1: begin
          c_dry = RawW'($urandom_range(0, 4095));
          c_wet = RawW'($urandom_range(0, 4095));
          c_vld = MvW'($urandom_range(0, 8191));
          c_sus = MvW'($urandom_range(0, 8191));
          c_con = MvW'($urandom_range(0, 8191));
          c_res = MvW'($urandom_range(0, 8191));
          c_lo  = PctW'($urandom_range(0, 100));
          c_hi  = PctW'($urandom_range(0, 100));
        end
        2: begin
          c_dry = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
          c_wet = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
          c_vld = $urandom_range(0, 1) ? 13'd8191 : 13'd0;
          c_sus = $urandom_range(0, 1) ? 13'd8191 : 13'd0;
          c_con = $urandom_range(0, 1) ? 13'd8191 : 13'd0;
          c_res = $urandom_range(0, 1) ? 13'd8191 : 13'd0;
          c_lo  = $urandom_range(0, 1) ? 7'd100 : 7'd0;
          c_hi  = $urandom_range(0, 1) ? 7'd100 : 7'd0;
        end
        3: begin
          c_dry = RawW'($urandom_range(0, 1500));
          c_wet = ($urandom_range(0, 2) == 0) ? c_dry : c_dry + RawW'($urandom_range(1, 2500));
        end
        default: ;
      endcase
      apply_cal(c_dry, c_wet, c_vld, c_sus, c_con, c_res, c_lo, c_hi);
      cal_lo = (c_dry < c_wet) ? int'(c_dry) : int'(c_wet);
      cal_hi = (c_dry < c_wet) ? int'(c_wet) : int'(c_dry);

      for (int k = 0; k < 120; k++) begin
        // Moisture: mostly a slow drift so that small display steps occur.
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          raw_walk = clamp_to(raw_walk + int'($urandom_range(0, 160)) - 80, 4095);
        end else if (pick < 8) begin
          raw_walk = clamp_to(cal_lo - 100 + int'($urandom_range(0, cal_hi - cal_lo + 200)),
                              4095);
        end else begin
          raw_walk = $urandom_range(0, 4095);
        end
        // Battery: drift, hover near a threshold, or jump anywhere.
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          mv_walk = clamp_to(mv_walk + int'($urandom_range(0, 160)) - 80, 8191);
        end else if (pick < 8) begin
          case ($urandom_range(0, 3))
            0:       mv_walk = int'(shadow.cal.valid_mv);
            1:       mv_walk = int'(shadow.cal.suspect_mv);
            2:       mv_walk = int'(shadow.cal.conserve_mv);
            default: mv_walk = int'(shadow.cal.resume_mv);
          endcase
          mv_walk = clamp_to(mv_walk + int'($urandom_range(0, 60)) - 30, 8191);
        end else begin
          mv_walk = $urandom_range(0, 8191);
        end
        brown = ($urandom_range(0, 24) == 0);
        offer_wake(raw_walk[RawW-1:0], mv_walk[MvW-1:0], brown);
        // Sender bursts: short ones with gaps, and now and then a long unbroken run.
        burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 8);
          idle_input($urandom_range(1, 30));
        end
      end
    end

    // Drain and verdict.
    idle_input(1);
    while (shadow.awaited.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (shadow.faults == 0 && shadow.awaited.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/snwp_pkg.sv
src/snwp_if.sv
src/snwp_cfg_regs.sv
src/snwp_serial_div.sv
src/snwp_policy.sv
src/sensor_node_wake_policy.sv
src/snwp_checker.sv
test/sensor_node_wake_policy_tb.sv
